@@ rtl/soa_pkg.sv @@
// Shared types and constants for the slab object allocator.
// Used by soa_ctrl, soa_datapath and slab_object_allocator; depends on nothing.
`timescale 1ns / 1ps

package soa_pkg;

    // Pool geometry; the beat fields are sized for these values.
    localparam int SLAB_COUNT = 16;
    localparam int MAX_SLOTS  = 64;
    localparam int SLAB_W     = 4;
    localparam int SLOT_W     = 6;
    localparam int LINK_W     = SLAB_W + 1;
    localparam int CHAIN_W    = SLOT_W + 1;
    localparam int USED_W     = 16;

    // End markers of the slab lists and the slot chains.
    localparam logic [LINK_W-1:0]  LINK_END = LINK_W'(SLAB_COUNT);
    localparam logic [CHAIN_W-1:0] SLOT_END = CHAIN_W'(MAX_SLOTS);

    // List tags.
    localparam logic [1:0] TAG_NONE    = 2'd0;
    localparam logic [1:0] TAG_FULL    = 2'd1;
    localparam logic [1:0] TAG_PARTIAL = 2'd2;
    localparam logic [1:0] TAG_FREE    = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_SLAB = 2'd1;
    localparam logic [1:0] STATUS_NO_SLOT = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_OBJECTS_PER_SLAB    = 1'b0;
    localparam logic CFG_MIN_AVAILABLE_SLABS = 1'b1;

    localparam logic [6:0] CFG_OBJECTS_RESET = 7'd64;
    localparam logic [4:0] CFG_MIN_RESET     = 5'd2;

    localparam logic ACTION_ALLOC = 1'b0;
    localparam logic ACTION_FREE  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [SLAB_W-1:0] slab_index;
        logic [SLOT_W-1:0] object_index;
    } soa_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLAB_W-1:0] result_slab;
        logic [SLOT_W-1:0] result_object;
        logic              slab_released;
    } soa_out_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PICK,
        OP_FCHECK,
        OP_SWEEP,
        OP_UNLINK,
        OP_PUSH,
        OP_POP_RD,
        OP_POP_WR,
        OP_EMIT
    } soa_op_t;

    typedef enum logic [1:0] {
        PICK_PARTIAL,
        PICK_FREE,
        PICK_CLAIM,
        PICK_NONE
    } soa_pick_t;

    typedef enum logic [2:0] {
        FREE_BAD,
        FREE_KEEP,
        FREE_RELEASE,
        FREE_TO_FREE,
        FREE_TO_PARTIAL
    } soa_free_t;

    typedef struct packed {
        soa_op_t    op;
        logic [1:0] push_tag;
        logic       release_slab;
    } soa_cmd_t;

    typedef struct packed {
        logic      is_free;
        soa_pick_t pick_kind;
        soa_free_t free_kind;
        logic      sweep_last;
        logic      pop_empty;
        logic      now_full;
        logic      out_busy;
    } soa_stat_t;

endpackage

@@ rtl/soa_ctrl.sv @@
// Controller state machine of the slab object allocator.
// Sequences datapath operations; depends on soa_pkg.
`timescale 1ns / 1ps

module soa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  soa_pkg::soa_stat_t stat,
    output soa_pkg::soa_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SWEEP,
        ST_UNLINK,
        ST_PUSH,
        ST_POP_RD,
        ST_POP_WR,
        ST_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] push_tag_reg, push_tag_next;
    logic       unl_push_reg, unl_push_next;
    logic       after_pop_reg, after_pop_next;
    logic       release_reg, release_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and the operation for this cycle.
    always_comb begin
        state_next     = state_reg;
        push_tag_next  = push_tag_reg;
        unl_push_next  = unl_push_reg;
        after_pop_next = after_pop_reg;
        release_next   = release_reg;
        cmd.op           = soa_pkg::OP_NONE;
        cmd.push_tag     = push_tag_reg;
        cmd.release_slab = release_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = soa_pkg::OP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                release_next = 1'b0;
                if (stat.is_free) begin
                    cmd.op         = soa_pkg::OP_FCHECK;
                    after_pop_next = 1'b0;
                    case (stat.free_kind)
                        soa_pkg::FREE_RELEASE: begin
                            release_next  = 1'b1;
                            unl_push_next = 1'b0;
                            state_next    = ST_UNLINK;
                        end
                        soa_pkg::FREE_TO_FREE: begin
                            push_tag_next = soa_pkg::TAG_FREE;
                            unl_push_next = 1'b1;
                            state_next    = ST_UNLINK;
                        end
                        soa_pkg::FREE_TO_PARTIAL: begin
                            push_tag_next = soa_pkg::TAG_PARTIAL;
                            unl_push_next = 1'b1;
                            state_next    = ST_UNLINK;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end else begin
                    cmd.op         = soa_pkg::OP_PICK;
                    push_tag_next  = soa_pkg::TAG_PARTIAL;
                    after_pop_next = 1'b1;
                    unl_push_next  = 1'b1;
                    case (stat.pick_kind)
                        soa_pkg::PICK_PARTIAL: state_next = ST_POP_RD;
                        soa_pkg::PICK_FREE:    state_next = ST_UNLINK;
                        soa_pkg::PICK_CLAIM:   state_next = ST_SWEEP;
                        default:               state_next = ST_DONE;
                    endcase
                end
            end
            ST_SWEEP: begin
                cmd.op = soa_pkg::OP_SWEEP;
                if (stat.sweep_last) begin
                    state_next = ST_PUSH;
                end
            end
            ST_UNLINK: begin
                cmd.op     = soa_pkg::OP_UNLINK;
                state_next = unl_push_reg ? ST_PUSH : ST_DONE;
            end
            ST_PUSH: begin
                cmd.op     = soa_pkg::OP_PUSH;
                state_next = after_pop_reg ? ST_POP_RD : ST_DONE;
            end
            ST_POP_RD: begin
                cmd.op     = soa_pkg::OP_POP_RD;
                state_next = stat.pop_empty ? ST_DONE : ST_POP_WR;
            end
            ST_POP_WR: begin
                cmd.op = soa_pkg::OP_POP_WR;
                if (stat.now_full) begin
                    push_tag_next  = soa_pkg::TAG_FULL;
                    unl_push_next  = 1'b1;
                    after_pop_next = 1'b0;
                    release_next   = 1'b0;
                    state_next     = ST_UNLINK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!stat.out_busy) begin
                    cmd.op     = soa_pkg::OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and sequencing registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            push_tag_reg  <= soa_pkg::TAG_NONE;
            unl_push_reg  <= 1'b0;
            after_pop_reg <= 1'b0;
            release_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            push_tag_reg  <= push_tag_next;
            unl_push_reg  <= unl_push_next;
            after_pop_reg <= after_pop_next;
            release_reg   <= release_next;
        end
    end

endmodule

@@ rtl/soa_datapath.sv @@
// Datapath of the slab object allocator: slab tables, list links, slot chain
// memory, configuration and the output register. Depends on soa_pkg.
`timescale 1ns / 1ps

module soa_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  soa_pkg::soa_cmd_t  cmd,
    output soa_pkg::soa_stat_t stat,
    input  soa_pkg::soa_in_t   s_data,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_wdata,
    output logic               m_valid,
    input  logic               m_ready,
    output soa_pkg::soa_out_t  m_data
);

    localparam int SC = soa_pkg::SLAB_COUNT;

    // Configuration.
    logic [6:0] objs_reg;
    logic [4:0] min_avail_reg;

    // Per-slab state.
    logic [SC-1:0]                 held_reg;
    logic [soa_pkg::USED_W-1:0]    used_reg  [SC];
    logic [1:0]                    tag_reg   [SC];
    logic [soa_pkg::LINK_W-1:0]    lnext_reg [SC];
    logic [soa_pkg::LINK_W-1:0]    lprev_reg [SC];
    logic [soa_pkg::CHAIN_W-1:0]   chead_reg [SC];
    logic [soa_pkg::LINK_W-1:0]    lhead_reg [3];
    logic [soa_pkg::LINK_W-1:0]    avail_reg;

    // Slot chain memory, one row per slab.
    logic [soa_pkg::CHAIN_W-1:0] chain_mem [SC * soa_pkg::MAX_SLOTS];
    logic [soa_pkg::CHAIN_W-1:0] rd_data_reg;

    // Working registers of the current item.
    soa_pkg::soa_in_t             in_reg;
    logic [soa_pkg::SLAB_W-1:0]   s_reg;
    logic [soa_pkg::CHAIN_W-1:0]  obj_reg;
    logic [soa_pkg::SLOT_W-1:0]   k_reg;
    soa_pkg::soa_out_t            res_reg;
    soa_pkg::soa_out_t            out_reg;
    logic                         out_valid_reg;

    logic [6:0]                   slots;
    logic [soa_pkg::USED_W-1:0]   slots_w;
    logic [soa_pkg::SLAB_W-1:0]   free_slab;
    logic                         any_free;
    logic [1:0]                   cur_tag;
    logic [soa_pkg::LINK_W-1:0]   cur_prev;
    logic [soa_pkg::LINK_W-1:0]   cur_next;
    logic [soa_pkg::USED_W-1:0]   cur_used;
    logic [soa_pkg::USED_W-1:0]   used_dec;
    logic [soa_pkg::CHAIN_W-1:0]  cur_chead;
    logic [1:0]                   unl_hidx;
    logic [1:0]                   push_hidx;
    logic [soa_pkg::LINK_W-1:0]   push_n;
    logic                         slot_bad;

    // Effective slot count: zero acts as one, large values clamp.
    always_comb begin
        if (objs_reg == 7'd0) begin
            slots = 7'd1;
        end else if (objs_reg > 7'(soa_pkg::MAX_SLOTS)) begin
            slots = 7'(soa_pkg::MAX_SLOTS);
        end else begin
            slots = objs_reg;
        end
    end
    assign slots_w = soa_pkg::USED_W'(slots);

    // Lowest unclaimed slab.
    always_comb begin
        free_slab = '0;
        for (int i = SC - 1; i >= 0; i--) begin
            if (!held_reg[i]) begin
                free_slab = soa_pkg::SLAB_W'(i);
            end
        end
    end
    assign any_free = ~&held_reg;

    // Reads of the current slab.
    assign cur_tag   = tag_reg[s_reg];
    assign cur_prev  = lprev_reg[s_reg];
    assign cur_next  = lnext_reg[s_reg];
    assign cur_used  = used_reg[s_reg];
    assign cur_chead = chead_reg[s_reg];
    assign used_dec  = cur_used - 1'b1;
    assign unl_hidx  = cur_tag - 2'd1;
    assign push_hidx = cmd.push_tag - 2'd1;
    assign push_n    = lhead_reg[push_hidx];
    assign slot_bad  = ({1'b0, in_reg.object_index} >= slots) || (cur_used == '0);

    // Status toward the controller.
    always_comb begin
        stat.is_free = (in_reg.action == soa_pkg::ACTION_FREE);
        if (lhead_reg[soa_pkg::TAG_PARTIAL - 2'd1] != soa_pkg::LINK_END) begin
            stat.pick_kind = soa_pkg::PICK_PARTIAL;
        end else if (lhead_reg[soa_pkg::TAG_FREE - 2'd1] != soa_pkg::LINK_END) begin
            stat.pick_kind = soa_pkg::PICK_FREE;
        end else if (any_free) begin
            stat.pick_kind = soa_pkg::PICK_CLAIM;
        end else begin
            stat.pick_kind = soa_pkg::PICK_NONE;
        end
        if (!held_reg[s_reg] || slot_bad) begin
            stat.free_kind = soa_pkg::FREE_BAD;
        end else if (used_dec == '0) begin
            stat.free_kind = ({1'b0, avail_reg} >= {1'b0, min_avail_reg}) ?
                             soa_pkg::FREE_RELEASE : soa_pkg::FREE_TO_FREE;
        end else if (used_dec == slots_w - 1'b1) begin
            stat.free_kind = soa_pkg::FREE_TO_PARTIAL;
        end else begin
            stat.free_kind = soa_pkg::FREE_KEEP;
        end
        stat.sweep_last = ({1'b0, k_reg} == slots - 7'd1);
        stat.pop_empty  = cur_chead[soa_pkg::CHAIN_W-1];
        stat.now_full   = (cur_used + 1'b1 == slots_w);
        stat.out_busy   = out_valid_reg && !m_ready;
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            objs_reg      <= soa_pkg::CFG_OBJECTS_RESET;
            min_avail_reg <= soa_pkg::CFG_MIN_RESET;
            held_reg      <= '0;
            avail_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SC; i++) begin
                used_reg[i] <= '0;
                tag_reg[i]  <= soa_pkg::TAG_NONE;
            end
            for (int i = 0; i < 3; i++) begin
                lhead_reg[i] <= soa_pkg::LINK_END;
            end
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == soa_pkg::CFG_OBJECTS_PER_SLAB) begin
                    objs_reg <= cfg_wdata;
                end else begin
                    min_avail_reg <= cfg_wdata[4:0];
                end
            end
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                soa_pkg::OP_PICK: begin
                    if (stat.pick_kind == soa_pkg::PICK_CLAIM) begin
                        held_reg[free_slab] <= 1'b1;
                        used_reg[free_slab] <= '0;
                    end
                end
                soa_pkg::OP_FCHECK: begin
                    if (stat.free_kind != soa_pkg::FREE_BAD) begin
                        used_reg[s_reg] <= used_dec;
                    end
                end
                soa_pkg::OP_UNLINK: begin
                    if (cur_tag != soa_pkg::TAG_NONE) begin
                        if (cur_prev == soa_pkg::LINK_END) begin
                            lhead_reg[unl_hidx] <= cur_next;
                        end
                        tag_reg[s_reg] <= soa_pkg::TAG_NONE;
                        if (cur_tag == soa_pkg::TAG_PARTIAL || cur_tag == soa_pkg::TAG_FREE) begin
                            avail_reg <= avail_reg - 1'b1;
                        end
                    end
                    if (cmd.release_slab) begin
                        held_reg[s_reg] <= 1'b0;
                    end
                end
                soa_pkg::OP_PUSH: begin
                    lhead_reg[push_hidx] <= {1'b0, s_reg};
                    tag_reg[s_reg]       <= cmd.push_tag;
                    if (cmd.push_tag == soa_pkg::TAG_PARTIAL ||
                        cmd.push_tag == soa_pkg::TAG_FREE) begin
                        avail_reg <= avail_reg + 1'b1;
                    end
                end
                soa_pkg::OP_POP_WR: begin
                    used_reg[s_reg] <= cur_used + 1'b1;
                end
                soa_pkg::OP_EMIT: begin
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Links, chain heads and working registers; undefined until written.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            soa_pkg::OP_LOAD: begin
                in_reg                <= s_data;
                s_reg                 <= s_data.slab_index;
                res_reg.status        <= soa_pkg::STATUS_OK;
                res_reg.result_slab   <= (s_data.action == soa_pkg::ACTION_FREE) ?
                                         s_data.slab_index : '0;
                res_reg.result_object <= '0;
                res_reg.slab_released <= 1'b0;
            end
            soa_pkg::OP_PICK: begin
                k_reg <= '0;
                case (stat.pick_kind)
                    soa_pkg::PICK_PARTIAL: begin
                        s_reg <= lhead_reg[soa_pkg::TAG_PARTIAL - 2'd1][soa_pkg::SLAB_W-1:0];
                        res_reg.result_slab <=
                            lhead_reg[soa_pkg::TAG_PARTIAL - 2'd1][soa_pkg::SLAB_W-1:0];
                    end
                    soa_pkg::PICK_FREE: begin
                        s_reg <= lhead_reg[soa_pkg::TAG_FREE - 2'd1][soa_pkg::SLAB_W-1:0];
                        res_reg.result_slab <=
                            lhead_reg[soa_pkg::TAG_FREE - 2'd1][soa_pkg::SLAB_W-1:0];
                    end
                    soa_pkg::PICK_CLAIM: begin
                        s_reg               <= free_slab;
                        res_reg.result_slab <= free_slab;
                    end
                    default: begin
                        res_reg.status <= soa_pkg::STATUS_NO_SLAB;
                    end
                endcase
            end
            soa_pkg::OP_FCHECK: begin
                if (!held_reg[s_reg]) begin
                    res_reg.status <= soa_pkg::STATUS_NO_SLAB;
                end else if (slot_bad) begin
                    res_reg.status <= soa_pkg::STATUS_NO_SLOT;
                end else begin
                    chead_reg[s_reg] <= {1'b0, in_reg.object_index};
                end
            end
            soa_pkg::OP_SWEEP: begin
                k_reg <= k_reg + 1'b1;
                if (stat.sweep_last) begin
                    chead_reg[s_reg] <= soa_pkg::CHAIN_W'(slots - 7'd1);
                end
            end
            soa_pkg::OP_UNLINK: begin
                if (cur_tag != soa_pkg::TAG_NONE) begin
                    if (cur_prev != soa_pkg::LINK_END) begin
                        lnext_reg[cur_prev[soa_pkg::SLAB_W-1:0]] <= cur_next;
                    end
                    if (cur_next != soa_pkg::LINK_END) begin
                        lprev_reg[cur_next[soa_pkg::SLAB_W-1:0]] <= cur_prev;
                    end
                end
                if (cmd.release_slab) begin
                    res_reg.slab_released <= 1'b1;
                end
            end
            soa_pkg::OP_PUSH: begin
                lnext_reg[s_reg] <= push_n;
                lprev_reg[s_reg] <= soa_pkg::LINK_END;
                if (push_n != soa_pkg::LINK_END) begin
                    lprev_reg[push_n[soa_pkg::SLAB_W-1:0]] <= {1'b0, s_reg};
                end
            end
            soa_pkg::OP_POP_RD: begin
                obj_reg <= cur_chead;
                if (cur_chead[soa_pkg::CHAIN_W-1]) begin
                    res_reg.status <= soa_pkg::STATUS_NO_SLOT;
                end
            end
            soa_pkg::OP_POP_WR: begin
                chead_reg[s_reg]      <= rd_data_reg;
                res_reg.result_object <= obj_reg[soa_pkg::SLOT_W-1:0];
            end
            soa_pkg::OP_EMIT: begin
                out_reg <= res_reg;
            end
            default: ;
        endcase
    end

    // Slot chain memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.op == soa_pkg::OP_SWEEP) begin
            chain_mem[{s_reg, k_reg}] <= (k_reg == '0) ? soa_pkg::SLOT_END :
                                         {1'b0, k_reg - 1'b1};
        end else if (cmd.op == soa_pkg::OP_FCHECK && stat.free_kind != soa_pkg::FREE_BAD) begin
            chain_mem[{s_reg, in_reg.object_index}] <= cur_chead;
        end
        if (cmd.op == soa_pkg::OP_POP_RD) begin
            rd_data_reg <= chain_mem[{s_reg, cur_chead[soa_pkg::SLOT_W-1:0]}];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ rtl/slab_object_allocator.sv @@
// Slab object allocator top level: one item at a time through a sequencer.
// Allocate from a partial slab: load, pick, chain head read and write, emit;
// a slab move adds an unlink and a push, claiming a new slab a sweep over
// every slot (chain initialization) and a push. A free checks the slot and
// may unlink and push the slab. A new item is taken while the result waits.
// Reset (aresetn low, synchronous): all slabs unclaimed, lists empty, registers
// at 64 objects per slab and 2 minimum available slabs; no clearing pass.
`timescale 1ns / 1ps

module slab_object_allocator (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  soa_pkg::soa_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output soa_pkg::soa_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_wdata
);

    soa_pkg::soa_cmd_t  cmd;
    soa_pkg::soa_stat_t stat;

    // Sequencer.
    soa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Tables, memory and output register.
    soa_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for slab_object_allocator: directed and random
// allocate/free beats checked against a behavioral model of the slab lists.
// Depends on soa_pkg and the slab_object_allocator RTL.
`timescale 1ns / 1ps

module tb_top;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    soa_pkg::soa_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    soa_pkg::soa_out_t m_data;
    logic              cfg_wr_en;
    logic              cfg_index;
    logic [6:0]        cfg_wdata;

    slab_object_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Clock with a 2 ns period.
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Allocator state mirrored by the predictor.
    logic            held_q [soa_pkg::SLAB_COUNT];
    int              used_q [soa_pkg::SLAB_COUNT];
    int              chain_next_q [soa_pkg::SLAB_COUNT][soa_pkg::MAX_SLOTS];
    int              chain_head_q [soa_pkg::SLAB_COUNT];
    int              link_next_q [soa_pkg::SLAB_COUNT];
    int              link_prev_q [soa_pkg::SLAB_COUNT];
    int              head_q [3];
    logic [1:0]      tag_q [soa_pkg::SLAB_COUNT];
    logic [6:0]      objects_reg;
    logic [4:0]      min_avail_reg;

    soa_pkg::soa_out_t expected_beats [$];
    int              mismatches;
    int              send_idle_pct;
    int              recv_idle_pct;

    function automatic int slots_in_use();
        int n;
        n = objects_reg;
        if (n == 0) n = 1;
        if (n > soa_pkg::MAX_SLOTS) n = soa_pkg::MAX_SLOTS;
        return n;
    endfunction

    function automatic void list_remove(int s);
        int p;
        int n;
        if (tag_q[s] == soa_pkg::TAG_NONE) return;
        p = link_prev_q[s];
        n = link_next_q[s];
        if (p >= soa_pkg::SLAB_COUNT) head_q[tag_q[s] - 1] = n;
        else link_next_q[p] = n;
        if (n < soa_pkg::SLAB_COUNT) link_prev_q[n] = p;
        tag_q[s] = soa_pkg::TAG_NONE;
    endfunction

    function automatic void list_push(int s, logic [1:0] t);
        int n;
        n = head_q[t - 1];
        link_next_q[s] = n;
        link_prev_q[s] = soa_pkg::SLAB_COUNT;
        if (n < soa_pkg::SLAB_COUNT) link_prev_q[n] = s;
        head_q[t - 1] = s;
        tag_q[s] = t;
    endfunction

    function automatic void list_move(int s, logic [1:0] t);
        list_remove(s);
        list_push(s, t);
    endfunction

    function automatic void reset_allocator();
        for (int i = 0; i < soa_pkg::SLAB_COUNT; i++) begin
            held_q[i] = 1'b0;
            used_q[i] = 0;
            tag_q[i] = soa_pkg::TAG_NONE;
            chain_head_q[i] = 0;
            link_next_q[i] = 0;
            link_prev_q[i] = 0;
        end
        for (int i = 0; i < 3; i++) head_q[i] = soa_pkg::SLAB_COUNT;
        objects_reg = soa_pkg::CFG_OBJECTS_RESET;
        min_avail_reg = soa_pkg::CFG_MIN_RESET;
    endfunction

    // True when the slot sits on the slab's free chain. Repeated frees can
    // make the chain loop back on itself, so the walk is bounded.
    function automatic bit slot_in_chain(int s, int obj);
        int walk;
        bit hit;
        hit = 0;
        walk = chain_head_q[s];
        for (int step = 0; step < soa_pkg::MAX_SLOTS && walk < soa_pkg::MAX_SLOTS && !hit;
             step++) begin
            if (walk == obj) hit = 1;
            walk = chain_next_q[s][walk];
        end
        return hit;
    endfunction

    // Works out the result beat of one request and updates the mirror.
    function automatic soa_pkg::soa_out_t predict_allocator(soa_pkg::soa_in_t req);
        soa_pkg::soa_out_t r;
        int s;
        int obj;
        int slots;
        int avail;
        r = '0;
        slots = slots_in_use();
        if (req.action == soa_pkg::ACTION_ALLOC) begin
            if (head_q[1] < soa_pkg::SLAB_COUNT) begin
                s = head_q[1];
            end else if (head_q[2] < soa_pkg::SLAB_COUNT) begin
                s = head_q[2];
                list_move(s, soa_pkg::TAG_PARTIAL);
            end else begin
                s = 0;
                while (s < soa_pkg::SLAB_COUNT && held_q[s]) s++;
                if (s >= soa_pkg::SLAB_COUNT) begin
                    r.status = soa_pkg::STATUS_NO_SLAB;
                    return r;
                end
                held_q[s] = 1'b1;
                used_q[s] = 0;
                for (int k = 0; k < slots; k++)
                    chain_next_q[s][k] = (k == 0) ? soa_pkg::MAX_SLOTS : k - 1;
                chain_head_q[s] = slots - 1;
                list_push(s, soa_pkg::TAG_PARTIAL);
            end
            r.result_slab = s[soa_pkg::SLAB_W-1:0];
            obj = chain_head_q[s];
            if (obj >= soa_pkg::MAX_SLOTS) begin
                r.status = soa_pkg::STATUS_NO_SLOT;
                return r;
            end
            chain_head_q[s] = chain_next_q[s][obj];
            used_q[s]++;
            if (used_q[s] == slots) list_move(s, soa_pkg::TAG_FULL);
            r.result_object = obj[soa_pkg::SLOT_W-1:0];
        end else begin
            s = req.slab_index;
            obj = req.object_index;
            r.result_slab = req.slab_index;
            if (!held_q[s]) begin
                r.status = soa_pkg::STATUS_NO_SLAB;
                return r;
            end
            if (obj >= slots || used_q[s] == 0) begin
                r.status = soa_pkg::STATUS_NO_SLOT;
                return r;
            end
            chain_next_q[s][obj] = chain_head_q[s];
            chain_head_q[s] = obj;
            used_q[s]--;
            if (used_q[s] == 0) begin
                avail = 0;
                for (int k = 0; k < soa_pkg::SLAB_COUNT; k++)
                    if (tag_q[k] == soa_pkg::TAG_PARTIAL || tag_q[k] == soa_pkg::TAG_FREE)
                        avail++;
                if (avail >= min_avail_reg) begin
                    list_remove(s);
                    held_q[s] = 1'b0;
                    r.slab_released = 1'b1;
                end else begin
                    list_move(s, soa_pkg::TAG_FREE);
                end
            end else if (used_q[s] == slots - 1) begin
                list_move(s, soa_pkg::TAG_PARTIAL);
            end
        end
        return r;
    endfunction

    // Sends one request beat; the prediction is made at the accepting edge.
    task automatic send_request(logic act, logic [3:0] slab, logic [5:0] obj);
        soa_pkg::soa_in_t req;
        req.action = act;
        req.slab_index = slab;
        req.object_index = obj;
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid = 1'b1;
        s_data = req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_beats.push_back(predict_allocator(req));
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic alloc_one();
        send_request(soa_pkg::ACTION_ALLOC, 4'($urandom), 6'($urandom));
    endtask

    // Frees a slot that is currently handed out, if any; else a random free.
    task automatic free_live_slot();
        int s;
        int obj;
        bit found;
        found = 0;
        s = 0;
        obj = 0;
        for (int tries = 0; tries < 40 && !found; tries++) begin
            s = $urandom_range(soa_pkg::SLAB_COUNT - 1);
            if (held_q[s] && used_q[s] > 0) begin
                obj = $urandom_range(slots_in_use() - 1);
                found = !slot_in_chain(s, obj);
            end
        end
        if (found) send_request(soa_pkg::ACTION_FREE, 4'(s), 6'(obj));
        else send_request(soa_pkg::ACTION_FREE, 4'($urandom), 6'($urandom));
    endtask

    // Waits for all results, then lets the sequencer settle.
    task automatic drain();
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_config(logic idx, logic [6:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == soa_pkg::CFG_OBJECTS_PER_SLAB) objects_reg = value;
        else min_avail_reg = value[4:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Releases every slot that is handed out and can still be freed.
    task automatic free_everything();
        for (int s = 0; s < soa_pkg::SLAB_COUNT; s++)
            for (int obj = 0; obj < slots_in_use(); obj++)
                if (held_q[s] && used_q[s] > 0 && !slot_in_chain(s, obj))
                    send_request(soa_pkg::ACTION_FREE, 4'(s), 6'(obj));
    endtask

    task automatic test_directed();
        write_config(soa_pkg::CFG_MIN_AVAILABLE_SLABS, 7'd0);
        write_config(soa_pkg::CFG_OBJECTS_PER_SLAB, 7'd1);
        // Every slab holds one slot: exhaust the pool, then one more.
        for (int i = 0; i < soa_pkg::SLAB_COUNT + 1; i++) alloc_one();
        // Frees of a slot out of range, and of an extreme slab and slot.
        send_request(soa_pkg::ACTION_FREE, 4'd15, 6'd63);
        send_request(soa_pkg::ACTION_FREE, 4'd0, 6'd0);
        send_request(soa_pkg::ACTION_FREE, 4'd0, 6'd0);
        send_request(soa_pkg::ACTION_FREE, 4'd15, 6'd0);
        // Grow slots past the clamp, then allocate and free again under the new size.
        write_config(soa_pkg::CFG_OBJECTS_PER_SLAB, 7'd127);
        alloc_one();
        send_request(soa_pkg::ACTION_FREE, 4'd1, 6'd0);
        send_request(soa_pkg::ACTION_FREE, 4'd1, 6'd0);
        alloc_one();
        alloc_one();
    endtask

    task automatic test_random_phase(int items, logic [6:0] objs, logic [4:0] min_av);
        free_everything();
        write_config(soa_pkg::CFG_OBJECTS_PER_SLAB, objs);
        write_config(soa_pkg::CFG_MIN_AVAILABLE_SLABS, {2'b0, min_av});
        for (int i = 0; i < items; i++) begin
            case ($urandom_range(19))
                0: send_request(soa_pkg::ACTION_FREE, 4'($urandom), 6'($urandom));
                1, 2, 3, 4, 5, 6, 7, 8, 9: free_live_slot();
                default: alloc_one();
            endcase
        end
    endtask

    // Result checker and receiver stalls.
    always @(posedge aclk) begin
        soa_pkg::soa_out_t exp_beat;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", m_data);
            end else begin
                exp_beat = expected_beats.pop_front();
                if (m_data !== exp_beat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_beat, m_data);
                end
            end
        end
    end

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        mismatches = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b1;
        cfg_wr_en = 1'b0;
        cfg_index = soa_pkg::CFG_OBJECTS_PER_SLAB;
        cfg_wdata = '0;
        reset_allocator();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 70;
        test_directed();
        test_random_phase(70, 7'd4, 5'd2);
        test_random_phase(60, 7'd0, 5'd16);
        send_idle_pct = 70;
        recv_idle_pct = 10;
        test_random_phase(70, 7'd64, 5'd1);
        test_random_phase(60, 7'd3, 5'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_phase(70, 7'd2, 5'd5);
        test_random_phase(50, 7'd100, 5'd3);
        drain();

        if (mismatches == 0 && expected_beats.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
